>>> rtl/weighted_mean_bad_cell_fill_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted mean bad cell fill block.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MEAN_BAD_CELL_FILL_TOP_MACROS_SVH
`define WEIGHTED_MEAN_BAD_CELL_FILL_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMBCF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMBCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/wmbcf_pkg.sv
// ----------------------------------------------------------------------------
// wmbcf_pkg
// Types and constants shared by the weighted mean bad cell fill modules.
// ----------------------------------------------------------------------------
package wmbcf_pkg;

	localparam int VALUE_W       = 24;
	localparam int WEIGHT_W      = 16;
	localparam int PROD_W        = VALUE_W + WEIGHT_W + 1;
	localparam int SUM_W         = 46;
	localparam int WTOT_W        = 22;
	localparam int MAX_CELLS_DEF = 64;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  pixel_value;
		logic                       pixel_finite;
		logic        [WEIGHT_W-1:0] weight;
		logic                       last_cell;
	} cell_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic                      out_finite;
		logic                      was_replaced;
		logic                      last_out;
	} cell_out_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               finite;
		logic               weight_nz;
	} cell_entry_t;

endpackage

>>> rtl/weighted_mean_bad_cell_fill_top.sv
// ----------------------------------------------------------------------------
// weighted_mean_bad_cell_fill_top
// Loads a grid one cell per transaction, forms the weighted mean of the finite
// cells and then plays the grid back with bad cells replaced by the mean.
//
// Input: a transaction is taken at a clock edge with start high and busy low.
// Each cell goes through capture, weight multiply and accumulate; busy stays
// high in between, so a new cell is taken only after the last is accumulated.
// The cell flagged last_cell, or the MAX_CELLS-th cell, closes the grid. The
// signed 46-bit sum is then divided by the weight total in a serial divider,
// one bit per cycle, and the cell store is read back one entry per cycle
// through its registered read port.
// Output: every cell appears for exactly one cycle with result_valid high, in
// load order, last_out on the final one. The first result of a grid follows
// the divide and the registered read, the rest one per cycle.
// busy drops after the final read is issued; a new grid may begin while the
// last results drain. The receiver cannot hold results off.
// Reset clears the control state and the sums; the cell store needs no
// clearing since only entries of the current grid are read.
// ----------------------------------------------------------------------------
`include "weighted_mean_bad_cell_fill_top_macros.svh"

module weighted_mean_bad_cell_fill_top #(
	parameter int MAX_CELLS = wmbcf_pkg::MAX_CELLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  wmbcf_pkg::cell_in_t  grid_cell,
	output logic                 result_valid,
	output wmbcf_pkg::cell_out_t result
);

	localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CNT_W  = $clog2(MAX_CELLS + 1);
	localparam int VAL_W  = wmbcf_pkg::VALUE_W;
	localparam int PRD_W  = wmbcf_pkg::PROD_W;
	localparam int SUM_W  = wmbcf_pkg::SUM_W;
	localparam int TOT_W  = wmbcf_pkg::WTOT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                state_q;
	logic [CNT_W-1:0]          cnt_q;
	wmbcf_pkg::cell_in_t       in_q;
	logic                      last_q;
	logic signed [PRD_W-1:0]   prod_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic        [TOT_W-1:0]   wtot_q;
	logic                      mean_ok_q;
	logic                      single_q;
	logic        [VAL_W-1:0]   mean_q;
	logic        [ADDR_W-1:0]  rd_k_q;
	logic                      rd_vld_s1;
	logic                      rd_last_s1;
	wmbcf_pkg::cell_out_t      result_q;
	logic                      result_valid_q;

	logic                      accept;
	logic                      rd_is_last;
	logic                      div_start;
	logic                      div_done;
	logic signed [SUM_W-1:0]   div_quo;
	logic signed [PRD_W-1:0]   prod_d;
	logic signed [SUM_W-1:0]   sum_next;
	logic        [TOT_W-1:0]   wtot_next;
	wmbcf_pkg::cell_entry_t    wr_entry;
	wmbcf_pkg::cell_entry_t    rd_entry;
	wmbcf_pkg::cell_out_t      res_d;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign rd_is_last = (CNT_W'(rd_k_q) == cnt_q - 1'b1);
	assign div_start  = (state_q == ST_ACC) && last_q;

	assign prod_d    = $signed(in_q.pixel_value) * $signed({1'b0, in_q.weight});
	assign sum_next  = sum_q + SUM_W'(prod_q);
	assign wtot_next = wtot_q + (in_q.pixel_finite ? TOT_W'(in_q.weight) : TOT_W'(0));

	assign wr_entry.value     = grid_cell.pixel_value;
	assign wr_entry.finite    = grid_cell.pixel_finite;
	assign wr_entry.weight_nz = |grid_cell.weight;

	wmbcf_cell_mem #(
		.DEPTH  (MAX_CELLS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (accept),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (wr_entry),
		.re    (state_q == ST_OUT),
		.raddr (rd_k_q),
		.rdata (rd_entry)
	);

	wmbcf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (wtot_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sum_q     <= '0;
			wtot_q    <= '0;
			rd_k_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (last_q) begin
						sum_q   <= '0;
						wtot_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						sum_q   <= sum_next;
						wtot_q  <= wtot_next;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						rd_k_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					rd_vld_s1 <= 1'b1;
					rd_k_q    <= rd_k_q + 1'b1;
					if (rd_is_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q   <= grid_cell;
			last_q <= grid_cell.last_cell || (cnt_q == CNT_W'(MAX_CELLS - 1));
		end
		if (state_q == ST_MUL) begin
			prod_q <= in_q.pixel_finite ? prod_d : PRD_W'(0);
		end
		if (div_start) begin
			mean_ok_q <= (wtot_next != '0);
			single_q  <= (cnt_q == CNT_W'(1));
		end
		if (div_done) begin
			mean_q <= div_quo[VAL_W-1:0];
		end
		if (state_q == ST_OUT) begin
			rd_last_s1 <= rd_is_last;
		end
	end

	always_comb begin
		res_d.last_out = rd_last_s1;
		if (single_q || (rd_entry.finite && rd_entry.weight_nz)) begin
			res_d.out_finite   = rd_entry.finite;
			res_d.out_value    = rd_entry.finite ? $signed(rd_entry.value) : '0;
			res_d.was_replaced = 1'b0;
		end else begin
			res_d.out_finite   = mean_ok_q;
			res_d.out_value    = mean_ok_q ? $signed(mean_q) : '0;
			res_d.was_replaced = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`WMBCF_ASSERT_NEXT(a_accept_to_mul, accept, state_q == ST_MUL,
		"An accepted cell did not move to the multiply step.")
	`WMBCF_ASSERT_SAME(a_done_in_div, div_done, state_q == ST_DIV,
		"The divider finished outside the divide state.")
	`WMBCF_ASSERT_SAME(a_out_has_cells, state_q == ST_OUT, cnt_q != '0,
		"Readout started on an empty grid.")
	`WMBCF_ASSERT_NEXT(a_sums_cleared, div_start, (sum_q == '0) && (wtot_q == '0),
		"The sums were not cleared when the grid closed.")
	`WMBCF_ASSERT_NEXT(a_last_read_gap, rd_vld_s1 && rd_last_s1, !rd_vld_s1,
		"A read followed the final read of a grid.")

endmodule

>>> rtl/wmbcf_cell_mem.sv
// ----------------------------------------------------------------------------
// wmbcf_cell_mem
// Grid cell store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wmbcf_cell_mem #(
	parameter int DEPTH  = wmbcf_pkg::MAX_CELLS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  wmbcf_pkg::cell_entry_t   wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output wmbcf_pkg::cell_entry_t   rdata
);

	wmbcf_pkg::cell_entry_t mem [DEPTH];
	wmbcf_pkg::cell_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/wmbcf_div.sv
// ----------------------------------------------------------------------------
// wmbcf_div
// Serial restoring divider, one quotient bit per cycle. Signed dividend,
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wmbcf_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [wmbcf_pkg::SUM_W-1:0]   dividend,
	input  logic        [wmbcf_pkg::WTOT_W-1:0]  divisor,
	output logic                                 done,
	output logic signed [wmbcf_pkg::SUM_W-1:0]   quotient
);

	localparam int N_W = wmbcf_pkg::SUM_W;
	localparam int D_W = wmbcf_pkg::WTOT_W;
	localparam int C_W = $clog2(N_W + 1);

	logic           run_q;
	logic           done_q;
	logic [C_W-1:0] cnt_q;
	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] den_q;
	logic           neg_q;

	logic [D_W:0]   trial;
	logic           fits;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= C_W'(N_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == C_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[N_W-1];
			quo_q <= dividend[N_W-1] ? N_W'(-dividend) : N_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? D_W'(trial - {1'b0, den_q}) : trial[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

>>> dv/weighted_mean_bad_cell_fill_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_mean_bad_cell_fill_top_tb
// Loads grids into the bad cell fill block, both directed corner grids and
// random ones. A behavioral model of the weighted mean predicts every
// emitted cell, and each result transaction is checked in order against it.
// ----------------------------------------------------------------------------
module weighted_mean_bad_cell_fill_top_tb;

	localparam int N_CELLS      = wmbcf_pkg::MAX_CELLS_DEF;
	localparam int VAL_W        = wmbcf_pkg::VALUE_W;
	localparam int WGT_W        = wmbcf_pkg::WEIGHT_W;
	localparam int ITEM_TARGET  = 250;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		wmbcf_pkg::cell_in_t c;
		bit                  drain_first;
	} pending_cell_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	wmbcf_pkg::cell_in_t  grid_cell = '0;
	logic                 result_valid;
	wmbcf_pkg::cell_out_t result;

	pending_cell_t        pend_q[$];
	wmbcf_pkg::cell_out_t fill_expect_q[$];

	logic [VAL_W-1:0] grid_val [N_CELLS];
	bit               grid_fin [N_CELLS];
	bit               grid_wnz [N_CELLS];
	longint           wsum = 0;
	longint           wtot = 0;
	int               ncell = 0;
	int               errors = 0;
	int               cycles = 0;
	int               sent = 0;
	logic             took = 1'b0;

	weighted_mean_bad_cell_fill_top #(
		.MAX_CELLS(N_CELLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.grid_cell(grid_cell),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Store one cell, accumulate it, and queue the whole filled grid when it closes.
	function automatic void fold_cell(wmbcf_pkg::cell_in_t c);
		int                   idx;
		int                   n;
		longint               mean;
		bit                   mean_ok;
		wmbcf_pkg::cell_out_t r;
		idx = (ncell < N_CELLS) ? ncell : N_CELLS - 1;
		grid_val[idx] = c.pixel_value;
		grid_fin[idx] = c.pixel_finite;
		grid_wnz[idx] = (c.weight != '0);
		if (c.pixel_finite) begin
			wsum += longint'($signed(c.pixel_value)) * longint'(c.weight);
			wtot += longint'(c.weight);
		end
		n = idx + 1;
		ncell = n;
		if (!c.last_cell && n < N_CELLS)
			return;
		mean_ok = (wtot != 0);
		mean = mean_ok ? wsum / wtot : 0;
		for (int k = 0; k < n; k++) begin
			if (n == 1 || (grid_fin[k] && grid_wnz[k])) begin
				r.out_finite   = grid_fin[k];
				r.out_value    = grid_fin[k] ? grid_val[k] : '0;
				r.was_replaced = 1'b0;
			end else begin
				r.out_finite   = mean_ok;
				r.out_value    = mean_ok ? mean[VAL_W-1:0] : '0;
				r.was_replaced = 1'b1;
			end
			r.last_out = (k == n - 1);
			fill_expect_q.push_back(r);
		end
		wsum = 0;
		wtot = 0;
		ncell = 0;
	endfunction

	function automatic void add_cell(logic [VAL_W-1:0] v, bit fin, logic [WGT_W-1:0] w,
			bit last, bit drain = 1'b0);
		pending_cell_t p;
		p.c.pixel_value  = v;
		p.c.pixel_finite = fin;
		p.c.weight       = w;
		p.c.last_cell    = last;
		p.drain_first    = drain;
		pend_q.push_back(p);
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pend_q.size() != 0 &&
					(!pend_q[0].drain_first || fill_expect_q.size() == 0) &&
					((sent >= 120 && sent < 175) || $urandom_range(99) >= 20)) begin
				grid_cell <= pend_q[0].c;
				start     <= 1'b1;
				void'(pend_q.pop_front());
				sent      <= sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		wmbcf_pkg::cell_out_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (fill_expect_q.size() == 0) begin
					$display("%0t: unexpected result: value %0d finite %0b",
						$time, result.out_value, result.out_finite,
						" replaced %0b last %0b", result.was_replaced,
						result.last_out);
					errors++;
				end else begin
					want = fill_expect_q.pop_front();
					if (result.out_value !== want.out_value ||
							result.out_finite !== want.out_finite ||
							result.was_replaced !== want.was_replaced ||
							result.last_out !== want.last_out) begin
						$display("%0t: mismatch: expected value %0d finite %0b",
							$time, want.out_value, want.out_finite,
							" replaced %0b last %0b,", want.was_replaced,
							want.last_out,
							" got value %0d finite %0b", result.out_value,
							result.out_finite,
							" replaced %0b last %0b", result.was_replaced,
							result.last_out);
						errors++;
					end
				end
			end
			if (start && !busy)
				fold_cell(grid_cell);
			took <= start && !busy;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** weighted_mean_bad_cell_fill_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int               grid_no;
		int               len;
		int               pick;
		bit               long_grid;
		bit               zero_grid;
		logic [VAL_W-1:0] v;
		logic [WGT_W-1:0] w;

		// One-cell grids pass through, even when bad.
		add_cell(24'h7FFFFF, 1'b1, 16'd5, 1'b1);
		add_cell(24'h123456, 1'b0, 16'hFFFF, 1'b1);
		add_cell(24'h800000, 1'b1, 16'd0, 1'b1);
		// Extremes at full weight; mean truncates toward zero.
		add_cell(24'h7FFFFF, 1'b1, 16'hFFFF, 1'b0);
		add_cell(24'h800000, 1'b1, 16'hFFFF, 1'b0);
		add_cell(24'h7FFFFF, 1'b0, 16'h0001, 1'b1);
		// No weight on any finite cell, so replaced cells stay non-finite.
		add_cell(24'h000100, 1'b1, 16'd0, 1'b0);
		add_cell(24'h7FFFFF, 1'b0, 16'd7, 1'b0);
		add_cell(24'h800000, 1'b1, 16'd0, 1'b1);
		// Negative odd sum over an even total.
		add_cell(-24'sd3, 1'b1, 16'd1, 1'b0);
		add_cell(-24'sd4, 1'b1, 16'd1, 1'b0);
		add_cell(24'h000000, 1'b0, 16'd3, 1'b1);
		// All good cells.
		add_cell(24'h000FFF, 1'b1, 16'd2, 1'b0);
		add_cell(24'hFFF000, 1'b1, 16'd9, 1'b1);
		// Maximum values at maximum weight with a zero-weight finite cell.
		add_cell(24'h7FFFFF, 1'b1, 16'hFFFF, 1'b0);
		add_cell(24'h7FFFFF, 1'b1, 16'hFFFF, 1'b0);
		add_cell(24'h7FFFFF, 1'b1, 16'hFFFF, 1'b0);
		add_cell(24'h000000, 1'b1, 16'd0, 1'b1);

		grid_no = 0;
		while (pend_q.size() < ITEM_TARGET) begin
			long_grid = (grid_no == 6);
			zero_grid = ($urandom_range(99) < 6);
			pick = $urandom_range(99);
			if (long_grid)
				len = N_CELLS;
			else if (pick < 70)
				len = $urandom_range(1, 4);
			else
				len = $urandom_range(5, 12);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(9);
				if (pick == 0)
					v = 24'h7FFFFF;
				else if (pick == 1)
					v = 24'h800000;
				else if (pick == 2)
					v = VAL_W'($urandom_range(16) - 8);
				else
					v = VAL_W'($urandom);
				pick = $urandom_range(99);
				if (zero_grid || pick < 15)
					w = '0;
				else if (pick < 25)
					w = 16'hFFFF;
				else if (pick < 45)
					w = WGT_W'($urandom_range(1, 15));
				else
					w = WGT_W'($urandom);
				add_cell(v, $urandom_range(99) < 85, w, !long_grid && i == len - 1,
					i == 0 && (grid_no == 0 || grid_no == 15));
			end
			grid_no++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || start)
			@(posedge clk);
		while (fill_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("** weighted_mean_bad_cell_fill_top: PASSED **");
		end else begin
			$display("** weighted_mean_bad_cell_fill_top: FAILED **");
		end
		$finish;
	end

endmodule
